### sv/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

    localparam int LEVEL_W   = 32;
    localparam int PHASE_W   = 3;
    localparam int CMD_W     = 2;
    localparam int DT_W      = 16;
    localparam int SUSTAIN_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int PROD_W    = LEVEL_W + DT_W;

    localparam int S_TDATA_W = 16;  // dt_ms
    localparam int S_TUSER_W = 2;   // command
    localparam int M_TDATA_W = 40;  // level, phase, zero fill

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [CMD_W-1:0]   t_cmd;

    localparam t_level FULL_SCALE   = '1;
    localparam t_level SUSTAIN_UNIT = t_level'(64'hFFFF_FFFF / 64'd127);

    // commands
    localparam t_cmd CMD_TICK    = 2'd0;
    localparam t_cmd CMD_TRIGGER = 2'd1;
    localparam t_cmd CMD_STOP    = 2'd2;
    localparam t_cmd CMD_OFF     = 2'd3;

    // envelope phases
    localparam t_phase PH_OFF     = 3'd0;
    localparam t_phase PH_ATTACK  = 3'd1;
    localparam t_phase PH_DECAY   = 3'd2;
    localparam t_phase PH_SUSTAIN = 3'd3;
    localparam t_phase PH_RELEASE = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd3;

    // rate * dt, clamped to full scale
    function automatic t_level sat_mul(input t_level rate, input logic [DT_W-1:0] dt);
        logic [PROD_W-1:0] p;
        p = PROD_W'(rate) * PROD_W'(dt);
        sat_mul = (p[PROD_W-1:LEVEL_W] != '0) ? FULL_SCALE : p[LEVEL_W-1:0];
    endfunction

endpackage

### sv/adsr_envelope_generator_top.sv
// ADSR envelope generator: one result transfer per input transfer.
// Pipeline: two register stages (input/product register, then the envelope state register,
// which is also the result register).
// Throughput: one command per cycle; the input stalls only while both stages hold data
// and the result transfer is held off.
// Reset (i_rst_n low, synchronous): phase off, level 0, all rates all ones, sustain 127 steps.
`timescale 1ns / 1ps

module adsr_envelope_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [adsr_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [15:0] dt_ms
    input  logic [adsr_pkg::S_TUSER_W-1:0]    s_axis_tuser,   // [1:0] command
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [adsr_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // [31:0] level, [34:32] phase
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adsr_pkg::CFG_W-1:0]        i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers. The sustain step is stored already
    // scaled to its target level (7-bit by constant multiply).
    // ---------------------------------------------------------------
    adsr_pkg::t_level r_atk_slope;
    adsr_pkg::t_level r_dec_slope;
    adsr_pkg::t_level r_rel_slope;
    adsr_pkg::t_level r_target;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atk_slope <= adsr_pkg::FULL_SCALE;
            r_dec_slope <= adsr_pkg::FULL_SCALE;
            r_rel_slope <= adsr_pkg::FULL_SCALE;
            r_target    <= adsr_pkg::t_level'(adsr_pkg::SUSTAIN_UNIT * 32'd127);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                adsr_pkg::REG_ATTACK:  r_atk_slope <= i_cfg_data[adsr_pkg::LEVEL_W-1:0];
                adsr_pkg::REG_DECAY:   r_dec_slope <= i_cfg_data[adsr_pkg::LEVEL_W-1:0];
                adsr_pkg::REG_RELEASE: r_rel_slope <= i_cfg_data[adsr_pkg::LEVEL_W-1:0];
                adsr_pkg::REG_SUSTAIN: r_target <= adsr_pkg::t_level'(
                    adsr_pkg::SUSTAIN_UNIT *
                    adsr_pkg::t_level'(i_cfg_data[adsr_pkg::SUSTAIN_W-1:0]));
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control. Stage A holds the command and the three
    // saturated step products; the envelope state register is the
    // result register, so it only moves when its old value has left.
    // ---------------------------------------------------------------
    logic r_a_vld;
    logic r_out_vld;
    logic w_b_free;   // result slot empty or being taken this cycle
    logic w_b_load;   // stage A commits into the state this cycle

    assign w_b_free      = !r_out_vld || m_axis_tready;
    assign w_b_load      = r_a_vld && w_b_free;
    assign s_axis_tready = !r_a_vld || w_b_free;

    adsr_pkg::t_cmd   r_a_cmd;
    adsr_pkg::t_level r_a_step_att;
    adsr_pkg::t_level r_a_step_dec;
    adsr_pkg::t_level r_a_step_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    // products depend only on dt and the rates, so they are formed at the input
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_a_cmd      <= s_axis_tuser[adsr_pkg::CMD_W-1:0];
            r_a_step_att <= adsr_pkg::sat_mul(r_atk_slope, s_axis_tdata[adsr_pkg::DT_W-1:0]);
            r_a_step_dec <= adsr_pkg::sat_mul(r_dec_slope, s_axis_tdata[adsr_pkg::DT_W-1:0]);
            r_a_step_rel <= adsr_pkg::sat_mul(r_rel_slope, s_axis_tdata[adsr_pkg::DT_W-1:0]);
        end
    end

    // ---------------------------------------------------------------
    // Envelope update. Trigger and stop advance by zero time, so only
    // an immediate (all-ones) rate moves the level on those commands.
    // An immediate attack falls through into decay in the same pass.
    // ---------------------------------------------------------------
    adsr_pkg::t_phase r_phase;
    adsr_pkg::t_level r_level;
    adsr_pkg::t_phase n_phase;
    adsr_pkg::t_level n_level;

    always_comb begin
        logic                      tick;
        logic                      att_imm;
        logic                      dec_imm;
        logic                      rel_imm;
        adsr_pkg::t_level          step_a;
        adsr_pkg::t_level          step_d;
        adsr_pkg::t_level          step_r;
        adsr_pkg::t_phase          ph_in;
        logic [adsr_pkg::LEVEL_W:0] att_sum;
        adsr_pkg::t_level          dec_lvl;
        logic                      dec_reach;
        logic                      rel_reach;
        adsr_pkg::t_phase          dec_phase;
        adsr_pkg::t_level          dec_level;

        tick    = (r_a_cmd == adsr_pkg::CMD_TICK);
        att_imm = (r_atk_slope == adsr_pkg::FULL_SCALE);
        dec_imm = (r_dec_slope == adsr_pkg::FULL_SCALE);
        rel_imm = (r_rel_slope == adsr_pkg::FULL_SCALE);
        step_a  = tick ? r_a_step_att : '0;
        step_d  = tick ? r_a_step_dec : '0;
        step_r  = tick ? r_a_step_rel : '0;

        case (r_a_cmd)
            adsr_pkg::CMD_TICK:    ph_in = r_phase;
            adsr_pkg::CMD_TRIGGER: ph_in = adsr_pkg::PH_ATTACK;
            adsr_pkg::CMD_STOP:    ph_in = adsr_pkg::PH_RELEASE;
            default:               ph_in = adsr_pkg::PH_OFF;
        endcase

        // attack: carry out of the sum means the step overshoots full scale
        att_sum = {1'b0, r_level} + {1'b0, step_a};

        // decay starts from full scale when attack was immediate
        dec_lvl   = (ph_in == adsr_pkg::PH_ATTACK) ? adsr_pkg::FULL_SCALE : r_level;
        dec_reach = (dec_lvl < r_target) || (step_d > (dec_lvl - r_target));
        if (dec_imm || dec_reach) begin
            dec_phase = adsr_pkg::PH_SUSTAIN;
            dec_level = r_target;
        end else begin
            dec_phase = adsr_pkg::PH_DECAY;
            dec_level = dec_lvl - step_d;
        end

        rel_reach = step_r > r_level;

        case (ph_in)
            adsr_pkg::PH_ATTACK: begin
                if (att_imm) begin
                    n_phase = dec_phase;
                    n_level = dec_level;
                end else if (att_sum[adsr_pkg::LEVEL_W]) begin
                    n_phase = adsr_pkg::PH_DECAY;
                    n_level = adsr_pkg::FULL_SCALE;
                end else begin
                    n_phase = adsr_pkg::PH_ATTACK;
                    n_level = att_sum[adsr_pkg::LEVEL_W-1:0];
                end
            end
            adsr_pkg::PH_DECAY: begin
                n_phase = dec_phase;
                n_level = dec_level;
            end
            adsr_pkg::PH_SUSTAIN: begin
                n_phase = adsr_pkg::PH_SUSTAIN;
                n_level = r_level;
            end
            adsr_pkg::PH_RELEASE: begin
                if (rel_imm || rel_reach) begin
                    n_phase = adsr_pkg::PH_OFF;
                    n_level = '0;
                end else begin
                    n_phase = adsr_pkg::PH_RELEASE;
                    n_level = r_level - step_r;
                end
            end
            default: begin
                // off, force off, and unused codes
                n_phase = adsr_pkg::PH_OFF;
                n_level = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= adsr_pkg::PH_OFF;
            r_level   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_b_load) begin
                r_phase <= n_phase;
                r_level <= n_level;
            end
            if (w_b_free) begin
                r_out_vld <= r_a_vld;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(adsr_pkg::M_TDATA_W - adsr_pkg::LEVEL_W - adsr_pkg::PHASE_W){1'b0}},
                            r_phase, r_level};

endmodule
